### rtl/core/ladder_pkg.sv
// ----------------------------------------------------------------------------
// ladder_pkg
// Shared constants, widths and the sequencer state type for the four-pole
// ladder low-pass unit.
// ----------------------------------------------------------------------------
package ladder_pkg;

  // Default widths of the sample port and of the filter state.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int STATE_WIDTH_DEF  = 24;

  // Fixed field widths.
  localparam int RATE_W   = 18;
  localparam int CUT_W    = 17;
  localparam int RES_W    = 16;

  // Fraction bits of the coefficient (Q1.20) and of the resonance (Q2.14).
  localparam int COEF_BITS = 20;
  localparam int RES_BITS  = 14;

  // Reset value of the sample rate register.
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

  // 2*pi in Q3.28, and the width of the second multiplier operand.
  localparam int MUL_B_W = 32;
  localparam logic signed [MUL_B_W-1:0] TWO_PI_Q28 = 32'sd1686629713;

  // The product cutoff*2pi is cut by 8 bits before the division.
  localparam int NUM_SHIFT = 8;
  localparam int NUM_W     = 40;
  localparam int DIV_STEPS = COEF_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NUM,
    ST_LOAD,
    ST_DIV,
    ST_DRIVE,
    ST_MUL,
    ST_UPD,
    ST_PUT
  } ladder_state_t;

endpackage

### rtl/core/four_pole_ladder_lowpass_unit.sv
// ----------------------------------------------------------------------------
// four_pole_ladder_lowpass_unit
// Resonant four-pole low-pass ladder filter in fixed point. One shared
// multiplier and a bit-serial divider run under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                    Beat carries
//  -------  -----------------------------------------  -------------------------
//  in       in_valid, in_ready                         sample_in, cutoff_hz,
//                                                      resonance
//  out      out_valid, out_ready                       sample_out
//  cfg      cfg_valid, cfg_ready                       sample_rate_hz
//
//  The 20-step restoring divider forms the coefficient and is skipped when
//  the coefficient saturates to 1.0; the four stage updates then run on the
//  shared multiplier. Reset (rst, synchronous) clears the stage values and
//  sets the sample rate to 48000. The input stays not ready while a sample
//  is worked; a result waiting on out_ready holds the sequencer in its final
//  step and never blocks configuration writes.
//
module four_pole_ladder_lowpass_unit #(
  parameter int SAMPLE_WIDTH = ladder_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = ladder_pkg::STATE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ladder_pkg::RATE_W-1:0]        sample_rate_hz,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
  input  logic [ladder_pkg::CUT_W-1:0]         cutoff_hz,
  input  logic [ladder_pkg::RES_W-1:0]         resonance,
  // Output channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [STATE_WIDTH-1:0]        sample_out
);

  localparam int FRAC_BITS = STATE_WIDTH - 4;
  localparam int SHIFT     = FRAC_BITS - (SAMPLE_WIDTH - 1);
  localparam int MUL_A_W   = (STATE_WIDTH + 1 > ladder_pkg::CUT_W + 1) ?
                             STATE_WIDTH + 1 : ladder_pkg::CUT_W + 1;
  localparam int PROD_W    = MUL_A_W + ladder_pkg::MUL_B_W;
  localparam int DRV_W     = STATE_WIDTH + 4;
  localparam int UPD_W     = STATE_WIDTH + 3;
  localparam int COEF_W    = ladder_pkg::COEF_BITS + 1;

  localparam logic signed [STATE_WIDTH-1:0] ONE_Q     = STATE_WIDTH'(1) <<< FRAC_BITS;
  localparam logic signed [STATE_WIDTH-1:0] STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [STATE_WIDTH-1:0] STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << ladder_pkg::COEF_BITS;

  ladder_pkg::ladder_state_t state, state_next;

  // Configuration and latched input beat.
  logic [ladder_pkg::RATE_W-1:0]   rate_hz;
  logic signed [SAMPLE_WIDTH-1:0]  sample_r;
  logic [ladder_pkg::CUT_W-1:0]    cutoff_r;
  logic [ladder_pkg::RES_W-1:0]    res_r;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0]             ma;
  logic signed [ladder_pkg::MUL_B_W-1:0] mb;
  logic signed [PROD_W-1:0]              prod;
  logic                                  prod_en;

  // Divider.
  logic [ladder_pkg::NUM_W-1:0] num_in;
  logic [ladder_pkg::NUM_W-1:0] rem;
  logic [ladder_pkg::NUM_W-1:0] dsh;
  logic [ladder_pkg::NUM_W:0]   trial;
  logic [ladder_pkg::CNT_W-1:0] cnt;
  logic [COEF_W-1:0]            coef;
  logic                         coef_sat;

  // Filter datapath.
  logic signed [STATE_WIDTH-1:0] stage [4];
  logic signed [STATE_WIDTH-1:0] prev;
  logic [1:0]                    idx;
  logic signed [STATE_WIDTH-1:0] x_conv;
  logic signed [STATE_WIDTH-1:0] rscl;
  logic signed [STATE_WIDTH:0]   diff;
  logic signed [STATE_WIDTH+2:0] fb;
  logic signed [DRV_W-1:0]       drive_w;
  logic signed [STATE_WIDTH-1:0] drive;
  logic signed [STATE_WIDTH+1:0] step;
  logic signed [UPD_W-1:0]       upd_w;
  logic signed [STATE_WIDTH-1:0] upd;

  assign cfg_ready = 1'b1;

  // Sample moved into the state format.
  generate
    if (SHIFT >= 0) begin : g_left
      assign x_conv = STATE_WIDTH'(sample_r) <<< SHIFT;
    end else begin : g_right
      assign x_conv = STATE_WIDTH'(sample_r >>> (-SHIFT));
    end
  endgenerate

  // Feedback source, clamped to 1.0 from above only.
  assign rscl = (stage[3] > ONE_Q) ? ONE_Q : stage[3];
  assign diff = (STATE_WIDTH+1)'(prev) - (STATE_WIDTH+1)'(stage[idx]);

  // Operand select for the shared multiplier.
  always_comb begin
    ma      = '0;
    mb      = '0;
    prod_en = 1'b0;
    case (state)
      ladder_pkg::ST_NUM: begin
        ma      = MUL_A_W'({1'b0, cutoff_r});
        mb      = ladder_pkg::TWO_PI_Q28;
        prod_en = 1'b1;
      end
      ladder_pkg::ST_LOAD: begin
        ma      = MUL_A_W'(rscl);
        mb      = ladder_pkg::MUL_B_W'({1'b0, res_r});
        prod_en = 1'b1;
      end
      ladder_pkg::ST_MUL: begin
        ma      = MUL_A_W'(diff);
        mb      = ladder_pkg::MUL_B_W'({1'b0, coef});
        prod_en = 1'b1;
      end
      default: begin
        prod_en = 1'b0;
      end
    endcase
  end

  // Division operands: coefficient = floor((cutoff*2pi >> 8) / rate).
  assign num_in   = prod[ladder_pkg::NUM_SHIFT +: ladder_pkg::NUM_W];
  assign coef_sat = num_in >= ladder_pkg::NUM_W'({rate_hz, {ladder_pkg::COEF_BITS{1'b0}}});
  assign trial    = {1'b0, rem} - {1'b0, dsh};

  // Drive: sample minus scaled feedback, saturated.
  assign fb      = prod[ladder_pkg::RES_BITS +: STATE_WIDTH+3];
  assign drive_w = DRV_W'(x_conv) - DRV_W'(fb);
  always_comb begin
    if (&drive_w[DRV_W-1:STATE_WIDTH-1] || ~|drive_w[DRV_W-1:STATE_WIDTH-1]) begin
      drive = drive_w[STATE_WIDTH-1:0];
    end else begin
      drive = drive_w[DRV_W-1] ? STATE_MIN : STATE_MAX;
    end
  end

  // One-pole update of the selected stage, saturated.
  assign step  = prod[ladder_pkg::COEF_BITS +: STATE_WIDTH+2];
  assign upd_w = UPD_W'(stage[idx]) + UPD_W'(step);
  always_comb begin
    if (&upd_w[UPD_W-1:STATE_WIDTH-1] || ~|upd_w[UPD_W-1:STATE_WIDTH-1]) begin
      upd = upd_w[STATE_WIDTH-1:0];
    end else begin
      upd = upd_w[UPD_W-1] ? STATE_MIN : STATE_MAX;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ladder_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ladder_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ladder_pkg::ST_NUM;
        end
      end
      ladder_pkg::ST_NUM: begin
        state_next = ladder_pkg::ST_LOAD;
      end
      ladder_pkg::ST_LOAD: begin
        state_next = coef_sat ? ladder_pkg::ST_DRIVE : ladder_pkg::ST_DIV;
      end
      ladder_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = ladder_pkg::ST_DRIVE;
        end
      end
      ladder_pkg::ST_DRIVE: begin
        state_next = ladder_pkg::ST_MUL;
      end
      ladder_pkg::ST_MUL: begin
        state_next = ladder_pkg::ST_UPD;
      end
      ladder_pkg::ST_UPD: begin
        state_next = (idx == 2'd3) ? ladder_pkg::ST_PUT : ladder_pkg::ST_MUL;
      end
      ladder_pkg::ST_PUT: begin
        if (!out_valid || out_ready) begin
          state_next = ladder_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ladder_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_hz <= ladder_pkg::RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rate_hz <= sample_rate_hz;
    end
  end

  // Input beat capture and product register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= sample_in;
      cutoff_r <= cutoff_hz;
      res_r    <= resonance;
    end
    if (prod_en) begin
      prod <= ma * mb;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    case (state)
      ladder_pkg::ST_LOAD: begin
        rem  <= num_in;
        dsh  <= ladder_pkg::NUM_W'({rate_hz, {(ladder_pkg::COEF_BITS-1){1'b0}}});
        cnt  <= ladder_pkg::CNT_W'(ladder_pkg::DIV_STEPS - 1);
        coef <= coef_sat ? COEF_ONE : '0;
      end
      ladder_pkg::ST_DIV: begin
        if (!trial[ladder_pkg::NUM_W]) begin
          rem <= trial[ladder_pkg::NUM_W-1:0];
        end
        coef <= {coef[COEF_W-2:0], ~trial[ladder_pkg::NUM_W]};
        dsh  <= dsh >> 1;
        cnt  <= cnt - 1'b1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // Stage values, running stage input and stage index.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        stage[i] <= '0;
      end
      idx <= '0;
    end else begin
      case (state)
        ladder_pkg::ST_DRIVE: begin
          prev <= drive;
          idx  <= '0;
        end
        ladder_pkg::ST_UPD: begin
          stage[idx] <= upd;
          prev       <= upd;
          idx        <= idx + 1'b1;
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // Output register: filled from stage four once the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ladder_pkg::ST_PUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ladder_pkg::ST_PUT && (!out_valid || out_ready)) begin
      sample_out <= stage[3];
    end
  end

  // The input is closed for the whole sample once a beat is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a beat");

  // Restoring division keeps the remainder below twice the shifted divisor.
  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    state == ladder_pkg::ST_DIV |-> {1'b0, rem} < {dsh, 1'b0})
    else $error("divider remainder out of range");

  // The coefficient never exceeds 1.0 when the stages use it.
  a_coef_range: assert property (@(posedge clk) disable iff (rst)
    state == ladder_pkg::ST_MUL |-> coef <= COEF_ONE)
    else $error("coefficient above 1.0");

  // A new result only appears from the final sequencer step.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ladder_pkg::ST_PUT)
    else $error("result raised outside the output step");

  // Stage updates only follow a multiply on the shared unit.
  a_upd_after_mul: assert property (@(posedge clk) disable iff (rst)
    state == ladder_pkg::ST_UPD |-> $past(state) == ladder_pkg::ST_MUL)
    else $error("stage update without a fresh product");

endmodule
